// File: sv/scoder_pkg.sv
// Shared constants and types for the S-coder byte stream cipher.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package scoder_pkg;

	localparam int KEY_DEPTH = 64;
	localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int LEN_W     = 7;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 6;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_CRYPT = 1'b1;

	// issue stage -> crypt stage
	typedef struct packed {
		logic              valid;
		logic              cmd;
		logic              last;
		logic [BYTE_W-1:0] data;
		logic [KEY_AW-1:0] addr;      // load index or crypt position
		logic [KEY_AW-1:0] nxt_addr;  // position + 1 (unused on wrap)
		logic              wrap;      // final position: add key[0]
		logic              wr_ok;     // index lies inside the store
	} issue_t;

	// key store write port, also registered on each accepted item for forwarding
	typedef struct packed {
		logic              we;
		logic [KEY_AW-1:0] addr;
		logic [BYTE_W-1:0] data;
	} key_wr_t;

endpackage

`default_nettype wire

// File: sv/scoder_if.sv
// Stream interfaces of the S-coder cipher: input item and result channels.
// Depends on scoder_pkg for the field widths.
`default_nettype none

interface scoder_item_if;
	import scoder_pkg::*;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [BYTE_W-1:0] data_in;
	logic [IDX_W-1:0]  key_index;
	logic              last_byte;

	modport source (output valid, cmd, data_in, key_index, last_byte, input ready);
	modport sink   (input valid, cmd, data_in, key_index, last_byte, output ready);
endinterface

interface scoder_result_if;
	import scoder_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_out;
	logic              last_out;

	modport source (output valid, data_out, last_out, input ready);
	modport sink   (input valid, data_out, last_out, output ready);
endinterface

`default_nettype wire

// File: sv/scoder_key_ram.sv
// Key byte store: one write port, two read ports, registered read data.
// Depends on scoder_pkg for depth and widths.
`default_nettype none

module scoder_key_ram (
	input  wire logic                        clk,
	input  wire scoder_pkg::key_wr_t         wr,
	input  wire logic                        rd_en,
	input  wire logic [scoder_pkg::KEY_AW-1:0] rd_addr_a,
	input  wire logic [scoder_pkg::KEY_AW-1:0] rd_addr_b,
	output logic      [scoder_pkg::BYTE_W-1:0] rd_data_a,
	output logic      [scoder_pkg::BYTE_W-1:0] rd_data_b
);
	import scoder_pkg::*;

	logic [BYTE_W-1:0] mem [KEY_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

`default_nettype wire

// File: sv/scoder_issue.sv
// Issue stage: key length register, key position, read addresses, stage 1 register.
// Depends on scoder_pkg and scoder_item_if.
`default_nettype none

module scoder_issue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [scoder_pkg::LEN_W-1:0] cfg_wdata,
	scoder_item_if.sink                       items,
	input  wire logic                         s1_adv,
	output scoder_pkg::issue_t                iss,
	output logic                              accept,
	output logic      [scoder_pkg::KEY_AW-1:0] rd_addr_a,
	output logic      [scoder_pkg::KEY_AW-1:0] rd_addr_b
);
	import scoder_pkg::*;

	logic [LEN_W-1:0]  key_length_q;
	logic [KEY_AW-1:0] pos_q;
	logic [LEN_W-1:0]  len_eff;
	logic [KEY_AW-1:0] pos_eff;
	logic [LEN_W-1:0]  nxt_full;
	logic              wrap;
	logic [KEY_AW-1:0] nxt_addr;
	logic              idx_ok;
	issue_t            iss_s1;

	always_comb begin
		if (key_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(key_length_q) > KEY_DEPTH) begin
			len_eff = LEN_W'(KEY_DEPTH);
		end else begin
			len_eff = key_length_q;
		end
		pos_eff  = (LEN_W'(pos_q) >= len_eff) ? '0 : pos_q;
		nxt_full = LEN_W'(pos_eff) + LEN_W'(1);
		wrap     = (nxt_full >= len_eff);
		nxt_addr = wrap ? '0 : KEY_AW'(nxt_full);
		idx_ok   = (32'(items.key_index) < KEY_DEPTH);
	end

	assign items.ready = !iss_s1.valid || s1_adv;
	assign accept      = items.valid && items.ready;
	assign rd_addr_a   = pos_eff;
	assign rd_addr_b   = nxt_addr;
	assign iss         = iss_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= LEN_W'(1);
		end else if (cfg_we) begin
			key_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= (items.cmd == CMD_LOAD) ? '0 : nxt_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
		end else if (accept) begin
			iss_s1.valid    <= 1'b1;
			iss_s1.cmd      <= items.cmd;
			iss_s1.last     <= items.last_byte;
			iss_s1.data     <= items.data_in;
			iss_s1.addr     <= (items.cmd == CMD_LOAD) ? KEY_AW'(items.key_index) : pos_eff;
			iss_s1.nxt_addr <= nxt_addr;
			iss_s1.wrap     <= wrap;
			iss_s1.wr_ok    <= (items.cmd == CMD_LOAD) ? idx_ok : 1'b1;
		end else if (s1_adv) begin
			iss_s1.valid <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_load_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && items.cmd == CMD_LOAD |=> pos_q == '0)
		else $error("key position not rewound after load");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept && items.cmd == CMD_CRYPT && !cfg_we |=> LEN_W'(pos_q) < len_eff)
		else $error("key position beyond key length after crypt");
`endif

endmodule

`default_nettype wire

// File: sv/scoder_crypt.sv
// Crypt stage: forwarding, keystream byte, key update write-back, result register.
// Depends on scoder_pkg and scoder_result_if.
`default_nettype none

module scoder_crypt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire scoder_pkg::issue_t            iss,
	input  wire logic                          accept,
	input  wire logic [scoder_pkg::BYTE_W-1:0] rd_data_a,
	input  wire logic [scoder_pkg::BYTE_W-1:0] rd_data_b,
	output logic                               s1_adv,
	output scoder_pkg::key_wr_t                wr,
	scoder_result_if.source                    results
);
	import scoder_pkg::*;

	key_wr_t             fwd_s1;
	logic [BYTE_W-1:0]   key0_q;
	logic                res_valid_q;
	logic [BYTE_W-1:0]   res_data_q;
	logic                res_last_q;
	logic [BYTE_W-1:0]   key_a;
	logic [BYTE_W-1:0]   key_b;
	logic [BYTE_W-1:0]   addend;
	logic [BYTE_W+KEY_AW-1:0] prod;
	logic [BYTE_W-1:0]   pad;
	logic [BYTE_W-1:0]   sum;
	logic [BYTE_W-1:0]   sum_fix;

	always_comb begin
		// write-back of the item ahead landed at the same edge as our read
		key_a   = (fwd_s1.we && fwd_s1.addr == iss.addr) ? fwd_s1.data : rd_data_a;
		key_b   = (fwd_s1.we && fwd_s1.addr == iss.nxt_addr) ? fwd_s1.data : rd_data_b;
		addend  = iss.wrap ? key0_q : key_b;
		prod    = (BYTE_W + KEY_AW)'(key0_q) * (BYTE_W + KEY_AW)'(iss.addr);
		pad     = key_a ^ prod[BYTE_W-1:0];
		sum     = key_a + addend;
		sum_fix = (sum == '0) ? BYTE_W'(1) : sum;
	end

	assign s1_adv  = iss.valid && (iss.cmd == CMD_LOAD || !res_valid_q || results.ready);
	assign wr.we   = s1_adv && iss.wr_ok;
	assign wr.addr = iss.addr;
	assign wr.data = (iss.cmd == CMD_LOAD) ? iss.data : sum_fix;

	assign results.valid    = res_valid_q;
	assign results.data_out = res_data_q;
	assign results.last_out = res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= '0;
		end else if (accept) begin
			fwd_s1 <= wr;
		end
	end

	// shadow of key[0] for the position multiply and the wrap addend
	always_ff @(posedge clk) begin
		if (wr.we && wr.addr == '0) begin
			key0_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv && iss.cmd == CMD_CRYPT) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && iss.cmd == CMD_CRYPT) begin
			res_data_q <= iss.data ^ pad;
			res_last_q <= iss.last;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_zero_key: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we && iss.cmd == CMD_CRYPT |-> wr.data != '0)
		else $error("crypt wrote a zero key byte");

	a_crypt_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && iss.cmd == CMD_CRYPT |=> res_valid_q)
		else $error("crypt item left no result");

	a_write_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> iss.valid && s1_adv)
		else $error("key write without an item leaving stage 1");
`endif

endmodule

`default_nettype wire

// File: sv/s_coder_stream_cipher.sv
// Top level of the S-coder byte stream cipher with self-modifying key.
// Depends on scoder_pkg, scoder_if, scoder_key_ram, scoder_issue, scoder_crypt.
//
//   channel   dir   handshake        beat
//   items     in    valid/ready      cmd, data_in, key_index, last_byte
//   results   out   valid/ready      data_out, last_out
//   cfg       in    cfg_we only      key_length (cfg_wdata)
//
// One beat per cycle sustained while no result beat is stalled, loads and crypts mixed freely.
// Path: a crypt beat's key bytes are read from the store at the edge that
// accepts it; stage 1 then forms the output byte and writes the updated key
// byte back as it advances, and the result beat is presented from the result register.
// Load beats pass the same two stages and produce no result beat.
// Reset: key position to zero, key length to 1; the key store is not cleared.
// A stalled result beat holds stage 1 for crypt beats only; loads drain freely.
`default_nettype none

module s_coder_stream_cipher (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	scoder_item_if.sink                       items,
	scoder_result_if.source                   results,
	input  wire logic                         cfg_we,
	input  wire logic [scoder_pkg::LEN_W-1:0] cfg_wdata
);
	import scoder_pkg::*;

	issue_t            iss;
	key_wr_t           wr;
	logic              accept;
	logic              s1_adv;
	logic [KEY_AW-1:0] rd_addr_a;
	logic [KEY_AW-1:0] rd_addr_b;
	logic [BYTE_W-1:0] rd_data_a;
	logic [BYTE_W-1:0] rd_data_b;

	// stage 0: position tracking and store read issue
	scoder_issue u_issue (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items),
		.s1_adv    (s1_adv),
		.iss       (iss),
		.accept    (accept),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b)
	);

	// key store: key[pos] on port A, key[pos+1] (key[0] on wrap) on port B
	scoder_key_ram u_key_ram (
		.clk       (clk),
		.wr        (wr),
		.rd_en     (accept),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// stage 1: keystream, key update write-back, result register
	scoder_crypt u_crypt (
		.clk       (clk),
		.arst_n    (arst_n),
		.iss       (iss),
		.accept    (accept),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.s1_adv    (s1_adv),
		.wr        (wr),
		.results   (results)
	);

endmodule

`default_nettype wire

// File: verif/scoder_cipher_checker.sv
// Watches the item, result and key-length ports of the S-coder cipher, predicts each result beat.
// Depends on scoder_pkg and the stream interfaces in scoder_if.
`timescale 1ns / 100ps

module scoder_cipher_checker
	import scoder_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	scoder_item_if           items,
	scoder_result_if         results,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} cipher_out_t;

	logic [BYTE_W-1:0] key_bytes [KEY_DEPTH];
	logic [KEY_AW-1:0] key_pos;
	logic [LEN_W-1:0]  key_len_reg;
	cipher_out_t       cipher_q [$];
	int                mismatches  = 0;
	int                outstanding = 0;
	int                out_beats   = 0;

	assign fail_count = mismatches;
	assign pending    = outstanding;

	// zero acts as one, anything past the store saturates
	function automatic int unsigned key_span(input logic [LEN_W-1:0] len);
		if (len == 0)
			return 1;
		if (len > KEY_DEPTH)
			return KEY_DEPTH;
		return len;
	endfunction

	// output byte for one crypt beat, then the key byte update and position step
	function automatic cipher_out_t crypt_byte(input logic [BYTE_W-1:0] din, input logic lst);
		int unsigned       len;
		int unsigned       pos;
		logic [BYTE_W-1:0] addend;
		logic [BYTE_W-1:0] sum;
		cipher_out_t       res;
		len = key_span(key_len_reg);
		pos = key_pos;
		if (pos >= len)
			pos = 0;
		res.data = din ^ key_bytes[pos] ^ BYTE_W'(key_bytes[0] * pos);
		res.last = lst;
		addend = (pos + 1 < len) ? key_bytes[pos + 1] : key_bytes[0];
		sum = key_bytes[pos] + addend;
		if (sum == 0)
			sum = 1;
		key_bytes[pos] = sum;
		pos = pos + 1;
		if (pos >= len)
			pos = 0;
		key_pos = KEY_AW'(pos);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cipher_out_t want;
		if (!arst_n) begin
			key_pos     = '0;
			key_len_reg = LEN_W'(1);
			cipher_q.delete();
			outstanding = 0;
		end else begin
			// results first: a beat leaving at this edge belongs to an earlier item
			if (results.valid && results.ready) begin
				out_beats++;
				if (cipher_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result beat %0d unexpected: data_out %02h last_out %0b",
							$time, out_beats, results.data_out, results.last_out);
				end else begin
					want = cipher_q.pop_front();
					if (results.data_out !== want.data || results.last_out !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result beat %0d: data_out exp %02h got %02h, last_out exp %0b got %0b",
								$time, out_beats, want.data, results.data_out,
								want.last, results.last_out);
					end
				end
			end
			if (cfg_we)
				key_len_reg = cfg_wdata;
			if (items.valid && items.ready) begin
				if (items.cmd == CMD_LOAD) begin
					key_bytes[items.key_index] = items.data_in;
					key_pos = '0;
				end else begin
					cipher_q.push_back(crypt_byte(items.data_in, items.last_byte));
				end
			end
			outstanding = cipher_q.size();
		end
	end

endmodule

// File: verif/s_coder_stream_cipher_test.sv
// Stimulus and verdict for the S-coder byte stream cipher: directed beats, then random phases.
// Depends on scoder_pkg, scoder_if, the cipher RTL and scoder_cipher_checker.
`timescale 1ns / 100ps

module s_coder_stream_cipher_test;
	import scoder_pkg::*;

	// cycles a load beat may still be in flight once the last result has left
	localparam int LOAD_SETTLE = 4;
	localparam int ITEM_TARGET = 900;
	localparam int HOLD_CYCLES = 200;

	typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;

	scoder_item_if   items_if ();
	scoder_result_if results_if ();

	s_coder_stream_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	scoder_cipher_checker check (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items_if),
		.results    (results_if),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// sender pacing: burst length and gap between bursts
	int       burst_left = 0;
	int       burst_max  = 1;
	int       gap_max    = 0;
	int       beats_sent = 0;
	// receiver pacing, set per phase by the stimulus
	rx_mode_t rx_mode    = RX_FREE;
	int       rx_period  = 2;
	int       rx_on      = 1;
	int       rx_tick    = 0;
	// long hold-off: requested by stimulus, counted down by the receiver
	bit       hold_req   = 1'b0;
	int       hold_left  = 0;
	// key bytes written since reset; a crypt may only read these
	bit       key_loaded [KEY_DEPTH];
	int       key_eff    = 1;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard limit, far beyond the slowest correct run
	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: ready changes on the falling edge only
	initial begin
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready = 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE: begin
						results_if.ready = 1'b1;
					end
					RX_RANDOM: begin
						results_if.ready = ($urandom_range(0, 9) < 7);
					end
					default: begin
						results_if.ready = ((rx_tick % rx_period) < rx_on);
						rx_tick++;
					end
				endcase
			end
		end
	end

	// one beat on the item channel; a fresh burst may open with a gap
	task automatic put_beat(input logic cmd, input logic [BYTE_W-1:0] data,
		input logic [IDX_W-1:0] idx, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, burst_max);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				@(negedge clk);
				items_if.valid = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		items_if.valid     = 1'b1;
		items_if.cmd       = cmd;
		items_if.data_in   = data;
		items_if.key_index = idx;
		items_if.last_byte = last;
		do @(posedge clk); while (!items_if.ready);
		if (cmd == CMD_LOAD)
			key_loaded[idx] = 1'b1;
		beats_sent++;
	endtask

	// stop offering beats, wait for every result and for loads to settle
	task automatic quiesce();
		@(negedge clk);
		items_if.valid = 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (LOAD_SETTLE) @(negedge clk);
	endtask

	task automatic set_key_length(input int len);
		quiesce();
		cfg_we    = 1'b1;
		cfg_wdata = LEN_W'(len);
		@(negedge clk);
		cfg_we = 1'b0;
		key_eff = (len == 0) ? 1 : (len > KEY_DEPTH) ? KEY_DEPTH : len;
	endtask

	initial begin
		int  len_picks [8];
		int  phase;
		int  len;
		int  n;
		bit  full_key;
		bit  no_idle;

		len_picks          = '{64, 1, 127, 0, 65, 2, 63, 33};
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		items_if.valid     = 1'b0;
		items_if.cmd       = CMD_LOAD;
		items_if.data_in   = '0;
		items_if.key_index = '0;
		items_if.last_byte = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed part, key length one after reset ---
		// all-zero key: the key byte sum comes out zero and is bumped to one
		put_beat(CMD_LOAD,  8'h00, 6'd0, 1'b0);
		put_beat(CMD_CRYPT, 8'h00, 6'd0, 1'b0);
		put_beat(CMD_CRYPT, 8'hFF, 6'd0, 1'b1);
		put_beat(CMD_CRYPT, 8'h5A, 6'd0, 1'b0);
		// zero length behaves as length one
		set_key_length(0);
		put_beat(CMD_CRYPT, 8'h80, 6'd0, 1'b1);
		put_beat(CMD_CRYPT, 8'h01, 6'd0, 1'b0);
		put_beat(CMD_LOAD,  8'hFF, 6'd63, 1'b1);
		// four-byte key; bytes 1 and 2 sum to 256 and wrap to zero
		set_key_length(4);
		put_beat(CMD_LOAD,  8'h80, 6'd1, 1'b0);
		put_beat(CMD_LOAD,  8'h80, 6'd2, 1'b0);
		put_beat(CMD_LOAD,  8'h3C, 6'd3, 1'b0);
		put_beat(CMD_LOAD,  8'hC3, 6'd0, 1'b0);
		// walks past the final position, which adds key byte zero
		repeat (7) put_beat(CMD_CRYPT, 8'($urandom), 6'd0, 1'($urandom));
		// position now 3; shrinking to 2 forces a wrap on the next crypt
		set_key_length(2);
		put_beat(CMD_CRYPT, 8'hA5, 6'd0, 1'b1);
		put_beat(CMD_CRYPT, 8'h3C, 6'd0, 1'b0);

		// --- random phases, each under a new key length ---
		phase = 0;
		while (beats_sent < ITEM_TARGET) begin
			if (phase < 8)
				len = len_picks[phase];
			else if ($urandom_range(0, 9) < 7)
				len = $urandom_range(1, 16);
			else if ($urandom_range(0, 1) == 1)
				len = $urandom_range(17, 64);
			else
				len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(65, 127);

			// every fourth phase runs flat out on both sides
			no_idle = (phase % 4 == 0);
			set_key_length(len);
			gap_max   = no_idle ? 0 : $urandom_range(1, 8);
			burst_max = $urandom_range(1, 20);
			rx_mode   = no_idle ? RX_FREE : ($urandom_range(0, 1) ? RX_RANDOM : RX_PATTERN);
			rx_period = $urandom_range(2, 7);
			rx_on     = $urandom_range(1, rx_period - 1);

			full_key = 1'b1;
			for (int i = 0; i < key_eff; i++)
				if (!key_loaded[i])
					full_key = 1'b0;

			// crypt straight away where the key allows: picks up the position
			// left by the previous phase, including one past the new length
			if (full_key && $urandom_range(0, 1) == 1)
				repeat ($urandom_range(1, 6))
					put_beat(CMD_CRYPT, 8'($urandom), 6'd0, 1'($urandom));

			if (!full_key || $urandom_range(0, 2) == 0)
				for (int i = 0; i < key_eff; i++)
					put_beat(CMD_LOAD, ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom),
						IDX_W'(i), 1'($urandom));
			repeat ($urandom_range(0, 2))
				put_beat(CMD_LOAD, 8'($urandom), IDX_W'($urandom), 1'($urandom));

			// receiver holds off long enough for the block to back up
			if (phase == 3 || phase % 9 == 5)
				hold_req = 1'b1;

			n = $urandom_range(10, 50);
			repeat (n) begin
				if ($urandom_range(0, 99) < 12)
					put_beat(CMD_LOAD, ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom),
						IDX_W'($urandom), 1'($urandom));
				else
					put_beat(CMD_CRYPT, 8'($urandom), IDX_W'($urandom), 1'($urandom));
			end
			phase++;
		end

		quiesce();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
sv/scoder_pkg.sv
sv/scoder_if.sv
sv/scoder_key_ram.sv
sv/scoder_issue.sv
sv/scoder_crypt.sv
sv/s_coder_stream_cipher.sv
verif/scoder_cipher_checker.sv
verif/s_coder_stream_cipher_test.sv
